>>> rtl/ske_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_pkg
// Types and constants shared by the spline knot evaluator: request and
// response payloads, request and status codes, knot kind helpers.
// ----------------------------------------------------------------------------
package ske_pkg;

    // Request codes
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_INSERT = 2'd2;
    localparam logic [1:0] REQ_EVAL   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    // Knot kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_VEC3 = 3'd2;

    // Multiplier operand width for coefficients (holds 12 * 2^31)
    localparam int C_W = 36;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         knot_index;
        logic [2:0]         knot_kind;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] knot_z;
        logic signed [31:0] knot_w;
        logic signed [31:0] param_t;
    } ske_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         result_kind;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_w;
    } ske_rsp_t;

    // Number of components a knot kind carries
    function automatic logic [2:0] comp_count(input logic [2:0] kind);
        logic [2:0] n;
        case (kind) inside
            3'd0, 3'd5: n = 3'd1;
            3'd1:       n = 3'd2;
            3'd2:       n = 3'd3;
            3'd3, 3'd4: n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/spline_knot_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_knot_evaluator_core
// Knot store with set/append/insert and curve evaluation, Bezier by
// de Casteljau or Catmull-Rom, on one shared four-lane multiply unit.
// ----------------------------------------------------------------------------
//  channel | ports                       | payload
//  input   | s_valid, s_ready, s_data    | ske_pkg::ske_req_t
//  result  | m_valid, m_ready, m_data    | ske_pkg::ske_rsp_t
//  config  | cfg_valid, cfg_ready        | cfg_data (interp mode)
//
//  Insert moves the knots at and above its position up one slot first.
//  Bezier runs one lerp per cycle within a level, through the four-lane
//  multiplier and a scratch with one read and one write port; the lerp
//  pipeline drains between levels. s_ready is high only while idle; a finished
//  result waits in the output register while the next item is taken.
//  Reset clears count, kind and mode; knot memories are not cleared.
// ----------------------------------------------------------------------------
module spline_knot_evaluator_core #(
    parameter int MAX_KNOTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ske_pkg::ske_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ske_pkg::ske_rsp_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    localparam int AW    = $clog2(MAX_KNOTS);
    localparam int CW    = $clog2(MAX_KNOTS + 1);
    localparam int CWD   = ske_pkg::C_W;
    localparam int MB_W  = FRAC_BITS + 2;
    localparam int PW    = CWD + MB_W;
    localparam int ACC_W = FRAC_BITS + 40;
    localparam int SH_W  = ACC_W - FRAC_BITS - 1;
    localparam int SC_W  = FRAC_BITS + 1 + CW;
    localparam logic signed [31:0] ONE_T32 = 32'sd1 <<< FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_T   = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_DEC       = 15'h0002,
        S_SHIFT     = 15'h0004,
        S_SHIFT_END = 15'h0008,
        S_INS       = 15'h0010,
        S_RD1       = 15'h0020,
        S_BZ        = 15'h0040,
        S_CR_SEG    = 15'h0080,
        S_CR_SQ     = 15'h0100,
        S_CR_CUBE   = 15'h0200,
        S_CR_RD     = 15'h0400,
        S_CR_COEF   = 15'h0800,
        S_CR_MUL    = 15'h1000,
        S_CR_FIN    = 15'h2000,
        S_OUT       = 15'h4000
    } state_t;

    function automatic logic signed [CWD-1:0] sx(input logic [31:0] v);
        return {{(CWD-32){v[31]}}, v};
    endfunction

    state_t state_reg, state_next;

    logic             mode_reg;
    logic [CW-1:0]    total_reg;
    logic [2:0]       kind_reg;
    ske_pkg::ske_req_t req_reg;
    logic [FRAC_BITS:0] t_reg;

    // Knot store and de Casteljau scratch
    logic [127:0] store_mem [MAX_KNOTS];
    logic [127:0] scr_mem   [MAX_KNOTS];
    logic         st_we, scr_we;
    logic [AW-1:0] st_waddr, st_raddr, scr_waddr;
    logic [127:0] st_wdata, scr_wdata, st_rdata_reg, scr_rdata_reg;
    logic [127:0] knot_word;

    // Insert shift
    logic [AW-1:0] pos_reg, sh_cnt_reg, wr_addr_reg;
    logic          wr_pend_reg;

    // Bezier pipeline
    logic [AW-1:0] lvl_reg, rd_cnt_reg, rpos_reg, bz_waddr_reg;
    logic          iss_reg, first_lvl_reg, rv_reg, wv_reg, level_done;
    logic [127:0]  prev_reg, a_reg, bz_src;

    // Shared multiplier
    logic signed [CWD-1:0]  mul_a [4];
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod_reg [4];

    // Catmull-Rom
    logic [AW-1:0]      org_reg;
    logic [FRAC_BITS:0] u_reg, u2_reg, u3_reg;
    logic [2:0]         cr_k_reg;
    logic [1:0]         mstep_reg;
    logic signed [31:0] p_reg [4][3];
    logic signed [CWD-1:0]  c1_reg [3], c2_reg [3], c3_reg [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [CW-1:0]  segs;
    logic [SC_W-1:0] sc;
    logic [CW:0]    org_full;

    // Results
    logic [2:0]  res_status_reg, res_kind_reg;
    logic [31:0] res_reg [4];
    logic        m_valid_reg, out_load;
    ske_pkg::ske_rsp_t m_data_reg;

    // Decode
    logic [6:0]  idx7, tot7, ins_pos7;
    logic        kind_match, full;
    logic [2:0]  dec_status, dec_kind;
    logic        dec_write, dec_first, dec_inc;
    logic [AW-1:0] dec_waddr;
    state_t      dec_next;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // Incoming knot with unused components zeroed
    always_comb begin
        logic [2:0]  cc;
        logic [31:0] kl [4];
        cc = ske_pkg::comp_count(req_reg.knot_kind);
        kl[0] = req_reg.knot_x;
        kl[1] = req_reg.knot_y;
        kl[2] = req_reg.knot_z;
        kl[3] = req_reg.knot_w;
        for (int j = 0; j < 4; j++) begin
            knot_word[32*j +: 32] = (3'(j) < cc) ? kl[j] : 32'd0;
        end
    end

    // Request decode
    assign idx7       = {1'b0, req_reg.knot_index};
    assign tot7       = 7'(total_reg);
    assign kind_match = (req_reg.knot_kind == kind_reg);
    assign full       = (total_reg == CW'(MAX_KNOTS));
    assign ins_pos7   = (req_reg.req_type == ske_pkg::REQ_APPEND || idx7 > tot7) ? tot7 : idx7;

    always_comb begin
        dec_status = ske_pkg::ST_OK;
        dec_kind   = ske_pkg::KIND_NONE;
        dec_write  = 1'b0;
        dec_first  = 1'b0;
        dec_inc    = 1'b0;
        dec_waddr  = '0;
        dec_next   = S_OUT;
        unique case (req_reg.req_type) inside
            ske_pkg::REQ_SET: begin
                if (idx7 >= tot7) begin
                    dec_status = ske_pkg::ST_IGNORED;
                end else if (!kind_match) begin
                    dec_status = ske_pkg::ST_MISMATCH;
                end else begin
                    dec_write = 1'b1;
                    dec_waddr = AW'(req_reg.knot_index);
                end
            end
            ske_pkg::REQ_APPEND, ske_pkg::REQ_INSERT: begin
                if (total_reg == '0) begin
                    dec_write = 1'b1;
                    dec_first = 1'b1;
                end else if (!kind_match) begin
                    dec_status = ske_pkg::ST_MISMATCH;
                end else if (full) begin
                    dec_status = ske_pkg::ST_FULL;
                end else if (ins_pos7 == tot7) begin
                    dec_write = 1'b1;
                    dec_inc   = 1'b1;
                    dec_waddr = AW'(total_reg);
                end else begin
                    dec_next = S_SHIFT;
                end
            end
            default: begin
                if (total_reg == '0) begin
                    dec_status = ske_pkg::ST_EMPTY;
                end else if (total_reg == CW'(1)) begin
                    dec_kind = kind_reg;
                    dec_next = S_RD1;
                end else if (!mode_reg) begin
                    if (ske_pkg::comp_count(kind_reg) == 3'd0) begin
                        dec_status = ske_pkg::ST_EMPTY;
                    end else begin
                        dec_kind = kind_reg;
                        dec_next = S_BZ;
                    end
                end else if (total_reg < CW'(4)) begin
                    dec_status = ske_pkg::ST_EMPTY;
                end else begin
                    dec_kind = ske_pkg::KIND_VEC3;
                    if (kind_reg == ske_pkg::KIND_VEC3) begin
                        dec_next = S_CR_SEG;
                    end
                end
            end
        endcase
    end

    // Catmull-Rom segment select
    assign segs     = total_reg - CW'(3);
    assign sc       = SC_W'(t_reg) * SC_W'(segs);
    assign org_full = sc[SC_W-1:FRAC_BITS];

    assign bz_src     = first_lvl_reg ? st_rdata_reg : scr_rdata_reg;
    assign level_done = !iss_reg && !rv_reg && !wv_reg;

    // Store write and read port selection
    always_comb begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = knot_word;
        st_raddr = '0;
        unique case (state_reg)
            S_DEC: begin
                st_we    = dec_write;
                st_waddr = dec_waddr;
            end
            S_SHIFT, S_SHIFT_END: begin
                st_we    = wr_pend_reg;
                st_waddr = wr_addr_reg;
                st_wdata = st_rdata_reg;
                st_raddr = sh_cnt_reg;
            end
            S_INS: begin
                st_we    = 1'b1;
                st_waddr = pos_reg;
            end
            S_BZ:    st_raddr = rd_cnt_reg;
            S_CR_RD: st_raddr = org_reg + AW'(cr_k_reg);
            default: ;
        endcase
    end

    // Scratch write: one lerp per lane
    always_comb begin
        scr_we    = (state_reg == S_BZ) && wv_reg;
        scr_waddr = bz_waddr_reg;
        for (int j = 0; j < 4; j++) begin
            scr_wdata[32*j +: 32] = a_reg[32*j +: 32] + prod_reg[j][FRAC_BITS +: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= store_mem[st_raddr];
        if (scr_we) begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        scr_rdata_reg <= scr_mem[rd_cnt_reg];
    end

    // Shared multiplier operand selection
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            mul_a[j] = '0;
        end
        mul_b = '0;
        unique case (state_reg)
            S_BZ: begin
                for (int j = 0; j < 4; j++) begin
                    mul_a[j] = sx(bz_src[32*j +: 32]) - sx(prev_reg[32*j +: 32]);
                end
                mul_b = $signed({1'b0, t_reg});
            end
            S_CR_SQ: begin
                mul_a[0] = $signed(CWD'(u_reg));
                mul_b    = $signed({1'b0, u_reg});
            end
            S_CR_CUBE: begin
                mul_a[0] = $signed(CWD'(prod_reg[0][FRAC_BITS +: FRAC_BITS+1]));
                mul_b    = $signed({1'b0, u_reg});
            end
            S_CR_MUL: begin
                for (int j = 0; j < 3; j++) begin
                    case (mstep_reg)
                        2'd0:    mul_a[j] = c1_reg[j];
                        2'd1:    mul_a[j] = c2_reg[j];
                        2'd2:    mul_a[j] = c3_reg[j];
                        default: mul_a[j] = '0;
                    endcase
                end
                case (mstep_reg)
                    2'd0:    mul_b = $signed({1'b0, u_reg});
                    2'd1:    mul_b = $signed({1'b0, u2_reg});
                    2'd2:    mul_b = $signed({1'b0, u3_reg});
                    default: mul_b = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 4; j++) begin
            prod_reg[j] <= mul_a[j] * mul_b;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_DEC;
            S_DEC:       state_next = dec_next;
            S_SHIFT:     if (sh_cnt_reg == pos_reg) state_next = S_SHIFT_END;
            S_SHIFT_END: state_next = S_INS;
            S_INS:       state_next = S_OUT;
            S_RD1:       state_next = S_OUT;
            S_BZ:        if (level_done && lvl_reg == AW'(1)) state_next = S_OUT;
            S_CR_SEG:    state_next = S_CR_SQ;
            S_CR_SQ:     state_next = S_CR_CUBE;
            S_CR_CUBE:   state_next = S_CR_RD;
            S_CR_RD:     if (cr_k_reg == 3'd4) state_next = S_CR_COEF;
            S_CR_COEF:   state_next = S_CR_MUL;
            S_CR_MUL:    if (mstep_reg == 2'd3) state_next = S_CR_FIN;
            S_CR_FIN:    state_next = S_OUT;
            S_OUT:       if (out_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= 1'b0;
            total_reg   <= '0;
            kind_reg    <= '0;
            m_valid_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            iss_reg     <= 1'b0;
            rv_reg      <= 1'b0;
            wv_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_DEC: begin
                    if (dec_first) begin
                        kind_reg  <= req_reg.knot_kind;
                        total_reg <= CW'(1);
                    end
                    if (dec_inc) begin
                        total_reg <= total_reg + CW'(1);
                    end
                    wr_pend_reg <= 1'b0;
                    iss_reg     <= 1'b1;
                    rv_reg      <= 1'b0;
                    wv_reg      <= 1'b0;
                end
                S_SHIFT:     wr_pend_reg <= 1'b1;
                S_SHIFT_END: wr_pend_reg <= 1'b0;
                S_INS:       total_reg   <= total_reg + CW'(1);
                S_BZ: begin
                    rv_reg <= iss_reg;
                    wv_reg <= rv_reg && (rpos_reg != '0);
                    if (iss_reg && rd_cnt_reg == lvl_reg) begin
                        iss_reg <= 1'b0;
                    end
                    if (level_done && lvl_reg != AW'(1)) begin
                        iss_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
            if (s_data.param_t < 32'sd0) begin
                t_reg <= '0;
            end else if (s_data.param_t > ONE_T32) begin
                t_reg <= ONE_T;
            end else begin
                t_reg <= s_data.param_t[FRAC_BITS:0];
            end
        end
        unique case (state_reg)
            S_DEC: begin
                res_status_reg <= dec_status;
                res_kind_reg   <= dec_kind;
                for (int j = 0; j < 4; j++) begin
                    res_reg[j] <= 32'd0;
                end
                sh_cnt_reg    <= AW'(total_reg - CW'(1));
                pos_reg       <= AW'(ins_pos7);
                lvl_reg       <= AW'(total_reg - CW'(1));
                rd_cnt_reg    <= '0;
                first_lvl_reg <= 1'b1;
                cr_k_reg      <= '0;
            end
            S_SHIFT: begin
                wr_addr_reg <= sh_cnt_reg + AW'(1);
                if (sh_cnt_reg != pos_reg) begin
                    sh_cnt_reg <= sh_cnt_reg - AW'(1);
                end
            end
            S_RD1: begin
                for (int j = 0; j < 4; j++) begin
                    res_reg[j] <= st_rdata_reg[32*j +: 32];
                end
            end
            S_BZ: begin
                // read issue, lerp operand capture, final write capture
                if (iss_reg) begin
                    rpos_reg <= rd_cnt_reg;
                    if (rd_cnt_reg != lvl_reg) begin
                        rd_cnt_reg <= rd_cnt_reg + AW'(1);
                    end
                end
                if (rv_reg) begin
                    prev_reg     <= bz_src;
                    a_reg        <= prev_reg;
                    bz_waddr_reg <= rpos_reg - AW'(1);
                end
                if (wv_reg && lvl_reg == AW'(1)) begin
                    for (int j = 0; j < 4; j++) begin
                        res_reg[j] <= scr_wdata[32*j +: 32];
                    end
                end
                if (level_done && lvl_reg != AW'(1)) begin
                    lvl_reg       <= lvl_reg - AW'(1);
                    rd_cnt_reg    <= '0;
                    first_lvl_reg <= 1'b0;
                end
            end
            S_CR_SEG: begin
                if (org_full >= {1'b0, segs}) begin
                    org_reg <= AW'(segs - CW'(1));
                    u_reg   <= ONE_T;
                end else begin
                    org_reg <= AW'(org_full);
                    u_reg   <= {1'b0, sc[FRAC_BITS-1:0]};
                end
            end
            S_CR_CUBE: u2_reg <= prod_reg[0][FRAC_BITS +: FRAC_BITS+1];
            S_CR_RD: begin
                if (cr_k_reg == 3'd0) begin
                    u3_reg <= prod_reg[0][FRAC_BITS +: FRAC_BITS+1];
                end else begin
                    for (int j = 0; j < 3; j++) begin
                        p_reg[2'(cr_k_reg - 3'd1)][j] <= st_rdata_reg[32*j +: 32];
                    end
                end
                cr_k_reg <= cr_k_reg + 3'd1;
            end
            S_CR_COEF: begin
                // cubic coefficients per lane
                for (int j = 0; j < 3; j++) begin
                    c1_reg[j] <= sx(p_reg[2][j]) - sx(p_reg[0][j]);
                    c2_reg[j] <= (sx(p_reg[0][j]) <<< 1) - (sx(p_reg[1][j]) <<< 2)
                                 - sx(p_reg[1][j]) + (sx(p_reg[2][j]) <<< 2)
                                 - sx(p_reg[3][j]);
                    c3_reg[j] <= (sx(p_reg[1][j]) <<< 1) + sx(p_reg[1][j])
                                 - (sx(p_reg[2][j]) <<< 1) - sx(p_reg[2][j])
                                 + sx(p_reg[3][j]) - sx(p_reg[0][j]);
                    acc_reg[j] <= {{(ACC_W-33-FRAC_BITS){p_reg[1][j][31]}},
                                   p_reg[1][j], {(FRAC_BITS+1){1'b0}}};
                end
                mstep_reg <= '0;
            end
            S_CR_MUL: begin
                if (mstep_reg != 2'd0) begin
                    for (int j = 0; j < 3; j++) begin
                        acc_reg[j] <= acc_reg[j]
                                      + {{(ACC_W-PW){prod_reg[j][PW-1]}}, prod_reg[j]};
                    end
                end
                mstep_reg <= mstep_reg + 2'd1;
            end
            S_CR_FIN: begin
                // floor shift and saturate to 32 bits
                for (int j = 0; j < 3; j++) begin
                    logic [SH_W-1:0] sh;
                    sh = acc_reg[j][ACC_W-1:FRAC_BITS+1];
                    if ((&sh[SH_W-1:31]) || !(|sh[SH_W-1:31])) begin
                        res_reg[j] <= sh[31:0];
                    end else if (sh[SH_W-1]) begin
                        res_reg[j] <= 32'h8000_0000;
                    end else begin
                        res_reg[j] <= 32'h7FFF_FFFF;
                    end
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.result_kind <= res_kind_reg;
            m_data_reg.res_x       <= res_reg[0];
            m_data_reg.res_y       <= res_reg[1];
            m_data_reg.res_z       <= res_reg[2];
            m_data_reg.res_w       <= res_reg[3];
        end
    end

endmodule

>>> tb/sv/spline_knot_evaluator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_knot_evaluator_core_tb
// Self-checking bench for the spline knot evaluator. A directed table covers
// empty store, kind mismatch, full store, ignored sets, one-knot evaluation,
// t clamping and Bezier mode, then Catmull-Rom mode; random knot edits and
// evaluations follow, each response checked against a behavioral model of store and curves.
// ----------------------------------------------------------------------------
module spline_knot_evaluator_core_tb;

    localparam int MAXK   = 16;
    localparam int FB     = 16;
    localparam int N_RAND = 1200;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ske_pkg::ske_req_t s_data;
    logic              m_valid;
    logic              m_ready;
    ske_pkg::ske_rsp_t m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    spline_knot_evaluator_core #(.MAX_KNOTS(MAXK), .FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Model state
    logic               mdl_mode;
    logic signed [31:0] kx [MAXK];
    logic signed [31:0] ky [MAXK];
    logic signed [31:0] kz [MAXK];
    logic signed [31:0] kw [MAXK];
    int                 knot_cnt;
    logic [2:0]         knot_kind_held;

    ske_pkg::ske_rsp_t pending_rsp [$];
    bit       fixed_rsp   [$];
    int       n_err;
    int       n_rsp;
    int       n_eval;
    int       send_idle;
    int       recv_idle;
    bit       hold_off;

    function automatic int comps_of(input logic [2:0] kind);
        case (kind)
            3'd0, 3'd5: return 1;
            3'd1:       return 2;
            3'd2:       return 3;
            3'd3, 3'd4: return 4;
            default:    return 0;
        endcase
    endfunction

    function automatic longint fshr(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint cr_comp(input longint p0, input longint p1,
                                       input longint p2, input longint p3,
                                       input longint u, input longint u2,
                                       input longint u3);
        longint c1, c2, c3, sum;
        c1  = p2 - p0;
        c2  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3  = -p0 + 3 * p1 - 3 * p2 + p3;
        sum = 2 * p1 * (64'sd1 <<< FB) + c1 * u + c2 * u2 + c3 * u3;
        return sat32(fshr(sum, FB + 1));
    endfunction

    // Apply one request to the model and return its response
    function automatic ske_pkg::ske_rsp_t knot_store_step(input ske_pkg::ske_req_t rq);
        ske_pkg::ske_rsp_t  r;
        logic signed [31:0] c [4];
        longint             t, u, u2, u3, sc, sa [MAXK][4];
        int                 idx, segs, org;
        r = '0;
        c[0] = rq.knot_x; c[1] = rq.knot_y; c[2] = rq.knot_z; c[3] = rq.knot_w;
        for (int j = 0; j < 4; j++)
            if (j >= comps_of(rq.knot_kind)) c[j] = '0;
        idx = rq.knot_index;
        case (rq.req_type)
            ske_pkg::REQ_SET: begin
                if (idx >= knot_cnt) r.status = ske_pkg::ST_IGNORED;
                else if (rq.knot_kind != knot_kind_held) r.status = ske_pkg::ST_MISMATCH;
                else begin
                    kx[idx] = c[0]; ky[idx] = c[1]; kz[idx] = c[2]; kw[idx] = c[3];
                    r.status = ske_pkg::ST_OK;
                end
            end
            ske_pkg::REQ_APPEND, ske_pkg::REQ_INSERT: begin
                if (rq.req_type == ske_pkg::REQ_APPEND) idx = knot_cnt;
                if (knot_cnt == 0) begin
                    kx[0] = c[0]; ky[0] = c[1]; kz[0] = c[2]; kw[0] = c[3];
                    knot_kind_held = rq.knot_kind;
                    knot_cnt = 1;
                    r.status = ske_pkg::ST_OK;
                end else if (rq.knot_kind != knot_kind_held) begin
                    r.status = ske_pkg::ST_MISMATCH;
                end else if (knot_cnt >= MAXK) begin
                    r.status = ske_pkg::ST_FULL;
                end else begin
                    if (idx > knot_cnt) idx = knot_cnt;
                    for (int i = knot_cnt; i > idx; i--) begin
                        kx[i] = kx[i-1]; ky[i] = ky[i-1]; kz[i] = kz[i-1]; kw[i] = kw[i-1];
                    end
                    kx[idx] = c[0]; ky[idx] = c[1]; kz[idx] = c[2]; kw[idx] = c[3];
                    knot_cnt++;
                    r.status = ske_pkg::ST_OK;
                end
            end
            default: begin
                t = rq.param_t;
                if (t < 0) t = 0;
                if (t > (64'sd1 <<< FB)) t = 64'sd1 <<< FB;
                if (knot_cnt == 0) begin
                    r.status = ske_pkg::ST_EMPTY;
                end else if (knot_cnt == 1) begin
                    r.result_kind = knot_kind_held;
                    r.res_x = kx[0]; r.res_y = ky[0]; r.res_z = kz[0]; r.res_w = kw[0];
                end else if (mdl_mode == 1'b0) begin
                    if (comps_of(knot_kind_held) == 0) begin
                        r.status = ske_pkg::ST_EMPTY;
                    end else begin
                        // de Casteljau, one lerp per component per level
                        for (int i = 0; i < knot_cnt; i++) begin
                            sa[i][0] = kx[i]; sa[i][1] = ky[i];
                            sa[i][2] = kz[i]; sa[i][3] = kw[i];
                        end
                        for (int l = knot_cnt - 1; l >= 1; l--)
                            for (int i = 0; i < l; i++)
                                for (int j = 0; j < 4; j++)
                                    sa[i][j] = sa[i][j]
                                        + fshr((sa[i+1][j] - sa[i][j]) * t, FB);
                        r.result_kind = knot_kind_held;
                        r.res_x = sa[0][0]; r.res_y = sa[0][1];
                        r.res_z = sa[0][2]; r.res_w = sa[0][3];
                    end
                end else if (knot_cnt < 4) begin
                    r.status = ske_pkg::ST_EMPTY;
                end else begin
                    segs = knot_cnt - 3;
                    sc   = t * segs;
                    org  = int'(sc >>> FB);
                    u    = sc & ((64'sd1 <<< FB) - 1);
                    if (org >= segs) begin
                        org = segs - 1;
                        u   = 64'sd1 <<< FB;
                    end
                    u2 = (u * u) >>> FB;
                    u3 = (u2 * u) >>> FB;
                    r.result_kind = ske_pkg::KIND_VEC3;
                    if (knot_kind_held == ske_pkg::KIND_VEC3) begin
                        r.res_x = cr_comp(kx[org], kx[org+1], kx[org+2], kx[org+3], u, u2, u3);
                        r.res_y = cr_comp(ky[org], ky[org+1], ky[org+2], ky[org+3], u, u2, u3);
                        r.res_z = cr_comp(kz[org], kz[org+1], kz[org+2], kz[org+3], u, u2, u3);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    // Response checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %p", $time, m_data);
                n_err++;
            end else begin
                ske_pkg::ske_rsp_t exp_r;
                exp_r = pending_rsp.pop_front();
                void'(fixed_rsp.pop_front());
                if (exp_r.status !== m_data.status || exp_r.result_kind !== m_data.result_kind
                        || exp_r.res_x !== m_data.res_x || exp_r.res_y !== m_data.res_y
                        || exp_r.res_z !== m_data.res_z || exp_r.res_w !== m_data.res_w) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, m_data);
                    n_err++;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one transfer; returns right after the accepting edge, valid still high
    task automatic send_req(input ske_pkg::ske_req_t rq, input bit use_fixed,
                            input ske_pkg::ske_rsp_t fixed_r);
        ske_pkg::ske_rsp_t mr;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mr = knot_store_step(rq);
        if (use_fixed && mr != fixed_r) begin
            $display("%0t: table row disagrees, expected %p model %p", $time, fixed_r, mr);
            n_err++;
        end
        pending_rsp.push_back(mr);
        fixed_rsp.push_back(use_fixed);
    endtask

    // Drop input valid after the last accepted transfer
    task automatic stop_send();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_mode(input logic m);
        int guard;
        guard = 0;
        stop_send();
        while (pending_rsp.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (200) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mdl_mode = m;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ske_pkg::ske_req_t mk(input logic [1:0] rt, input logic [5:0] ix,
                                             input logic [2:0] kd, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z,
                                             input logic [31:0] w, input logic [31:0] t);
        ske_pkg::ske_req_t q;
        q.req_type = rt; q.knot_index = ix; q.knot_kind = kd;
        q.knot_x = x; q.knot_y = y; q.knot_z = z; q.knot_w = w; q.param_t = t;
        return q;
    endfunction

    function automatic ske_pkg::ske_rsp_t st_only(input logic [2:0] s);
        ske_pkg::ske_rsp_t r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    function automatic ske_pkg::ske_req_t rand_req(input logic [2:0] kd);
        ske_pkg::ske_req_t q;
        int       p;
        q = '0;
        p = $urandom_range(99);
        q.req_type   = (p < 30) ? ske_pkg::REQ_EVAL : (p < 55) ? ske_pkg::REQ_APPEND
                     : (p < 75) ? ske_pkg::REQ_INSERT : ske_pkg::REQ_SET;
        q.knot_index = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(17));
        q.knot_kind  = ($urandom_range(15) == 0) ? 3'($urandom) : kd;
        for (int j = 0; j < 5; j++) begin
            logic [31:0] v;
            case ($urandom_range(5))
                0: v = 32'h7fffffff;
                1: v = 32'h80000000;
                2: v = $urandom;
                default: v = 32'($signed($urandom_range(400000)) - 200000);
            endcase
            case (j)
                0: q.knot_x = v; 1: q.knot_y = v; 2: q.knot_z = v; 3: q.knot_w = v;
                default: q.param_t = ($urandom_range(3) == 0) ? v
                                   : 32'($urandom_range(65536));
            endcase
        end
        return q;
    endfunction

    typedef struct {
        ske_pkg::ske_req_t rq;
        bit                has_fixed;
        ske_pkg::ske_rsp_t fixed_r;
    } stim_row_t;

    // Stimulus
    initial begin
        stim_row_t rows [$];
        ske_pkg::ske_rsp_t r1;
        int        guard;
        logic [2:0] kd;
        s_valid = 1'b0; s_data = '0; cfg_valid = 1'b0; cfg_data = 1'b0;
        aresetn = 1'b0; mdl_mode = 1'b0; knot_cnt = 0; knot_kind_held = ske_pkg::KIND_NONE;
        n_err = 0; n_rsp = 0; n_eval = 0; hold_off = 1'b0;
        send_idle = 0; recv_idle = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        r1 = '0; r1.result_kind = 3'd3;
        r1.res_x = 32'h7fffffff; r1.res_y = 32'h80000000; r1.res_z = 32'h1; r1.res_w = -32'sd1;
        rows.push_back('{mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 0), 1,
                         st_only(ske_pkg::ST_EMPTY)});
        rows.push_back('{mk(ske_pkg::REQ_SET, 0, 0, 1, 0, 0, 0, 0), 1,
                         st_only(ske_pkg::ST_IGNORED)});
        rows.push_back('{mk(ske_pkg::REQ_INSERT, 63, 3, 32'h7fffffff, 32'h80000000, 1,
                            32'hffffffff, 0), 1, st_only(ske_pkg::ST_OK)});
        rows.push_back('{mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h80000000), 1, r1});
        rows.push_back('{mk(ske_pkg::REQ_APPEND, 0, 2, 5, 5, 5, 5, 0), 1,
                         st_only(ske_pkg::ST_MISMATCH)});
        rows.push_back('{mk(ske_pkg::REQ_SET, 0, 7, 5, 5, 5, 5, 0), 1,
                         st_only(ske_pkg::ST_MISMATCH)});
        rows.push_back('{mk(ske_pkg::REQ_APPEND, 0, 3, 32'h80000000, 32'h7fffffff, 0,
                            32'h10000, 0), 1, st_only(ske_pkg::ST_OK)});
        rows.push_back('{mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h7fffffff), 0, '0});
        rows.push_back('{mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h8000), 0, '0});
        for (int i = 0; i < 14; i++)
            rows.push_back('{mk(ske_pkg::REQ_INSERT, 6'(i), 3, 32'(i << 18), 32'(-i << 17),
                                32'(i * 777), 32'(i), 0), 1, st_only(ske_pkg::ST_OK)});
        rows.push_back('{mk(ske_pkg::REQ_APPEND, 0, 3, 1, 2, 3, 4, 0), 1,
                         st_only(ske_pkg::ST_FULL)});
        rows.push_back('{mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h6000), 0, '0});
        rows.push_back('{mk(ske_pkg::REQ_SET, 15, 3, 9, 9, 9, 9, 0), 1,
                         st_only(ske_pkg::ST_OK)});
        foreach (rows[i]) send_req(rows[i].rq, rows[i].has_fixed, rows[i].fixed_r);

        // Catmull-Rom on a non-vec3 store reads all zero
        write_mode(1'b1);
        send_req(mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h10000), 0, '0);
        send_req(mk(ske_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 32'h4000), 0, '0);

        // Random phases on the same store; mode and idling vary
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle = 16; recv_idle = 82; end
                1: begin send_idle = 82; recv_idle = 16; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            // the store cannot be emptied, so knots are rewritten by set/insert
            write_mode(ph[0]);
            kd = (ph == 3) ? 3'd6 : (ph % 3 == 1) ? ske_pkg::KIND_VEC3 : 3'($urandom_range(5));
            if (ph == 4) hold_off = 1'b1;
            for (int n = 0; n < N_RAND / 6; n++) begin
                ske_pkg::ske_req_t q;
                q = rand_req(knot_cnt == 0 ? kd : knot_kind_held);
                if (q.req_type == ske_pkg::REQ_EVAL) n_eval++;
                send_req(q, 0, '0);
            end
        end

        stop_send();
        guard = 0;
        while (pending_rsp.size() != 0 && guard < 500000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (300) @(negedge aclk);
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
            n_err++;
        end
        $display("Ran directed table plus random edits across both curve modes:");
        $display("  %0d responses checked, %0d random evaluations", n_rsp, n_eval);
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ske_pkg.sv
rtl/spline_knot_evaluator_core.sv
tb/sv/spline_knot_evaluator_core_tb.sv
